// File: rtl/pfa_pkg.sv
// Package for the partition fit allocator.
// Holds request, status and mode codes, the sequencer state type and the
// control structs shared by the top level and the slot cells.
package pfa_pkg;

    localparam int REQ_W  = 2;
    localparam int BIDX_W = 4;
    localparam int SVAL_W = 16;
    localparam int STAT_W = 2;
    localparam int MODE_W = 2;

    localparam logic [REQ_W-1:0] REQ_LOAD    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ALLOC   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_RESTART = 2'd2;

    localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] STAT_GRANT = 2'd1;
    localparam logic [STAT_W-1:0] STAT_MISS  = 2'd2;

    localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BEST  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_WORST = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_state;

    typedef struct packed {
        logic load;
        logic restart;
        logic grant;
    } t_cell_cmd;

    typedef struct packed {
        logic valid;
        logic found;
        logic best;
        logic worst;
    } t_scan_ctl;

endpackage

// File: rtl/pfa_cell.sv
// One partition slot of the allocator chain.
// Holds the slot's sizes and valid mark and updates the passing search word.
// Depends on pfa_pkg.
module pfa_cell #(
    parameter int SIZE_BITS = 16,
    parameter int IDX_BITS  = 4,
    parameter int INDEX     = 0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  pfa_pkg::t_cell_cmd    i_cmd,
    input  logic [IDX_BITS-1:0]   i_cmd_idx,
    input  logic [SIZE_BITS-1:0]  i_cmd_size,
    input  pfa_pkg::t_scan_ctl    i_scan,
    input  logic [SIZE_BITS-1:0]  i_scan_val,
    input  logic [IDX_BITS-1:0]   i_scan_idx,
    input  logic [SIZE_BITS-1:0]  i_scan_size,
    output pfa_pkg::t_scan_ctl    o_scan,
    output logic [SIZE_BITS-1:0]  o_scan_val,
    output logic [IDX_BITS-1:0]   o_scan_idx,
    output logic [SIZE_BITS-1:0]  o_scan_size
);
    import pfa_pkg::*;

    logic                 r_valid;
    logic                 n_valid;
    logic [SIZE_BITS-1:0] r_orig;
    logic [SIZE_BITS-1:0] n_orig;
    logic [SIZE_BITS-1:0] r_remain;
    logic [SIZE_BITS-1:0] n_remain;
    t_scan_ctl            r_scan;
    t_scan_ctl            n_scan;
    logic [SIZE_BITS-1:0] r_scan_val;
    logic [SIZE_BITS-1:0] n_scan_val;
    logic [IDX_BITS-1:0]  r_scan_idx;
    logic [IDX_BITS-1:0]  n_scan_idx;
    logic [SIZE_BITS-1:0] r_scan_size;
    logic                 sel;
    logic                 fits;
    logic                 take;

    always_comb begin
        sel  = (i_cmd_idx == IDX_BITS'(INDEX));
        fits = r_valid && (r_remain >= i_scan_size);
        take = i_scan.valid && fits &&
               (!i_scan.found ||
                (i_scan.best && (r_remain < i_scan_val)) ||
                (i_scan.worst && (r_remain > i_scan_val)));

        n_valid  = r_valid;
        n_orig   = r_orig;
        n_remain = r_remain;
        if (i_cmd.load && sel) begin
            n_valid  = 1'b1;
            n_orig   = i_cmd_size;
            n_remain = i_cmd_size;
        end else if (i_cmd.restart) begin
            n_remain = r_orig;
        end else if (i_cmd.grant && sel) begin
            n_remain = r_remain - i_cmd_size;
        end

        n_scan       = i_scan;
        n_scan.found = i_scan.found || take;
        n_scan_val   = take ? r_remain : i_scan_val;
        n_scan_idx   = take ? IDX_BITS'(INDEX) : i_scan_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_scan  <= '0;
        end else begin
            r_valid <= n_valid;
            r_scan  <= n_scan;
        end
    end

    always_ff @(posedge i_clk) begin
        r_orig      <= n_orig;
        r_remain    <= n_remain;
        r_scan_val  <= n_scan_val;
        r_scan_idx  <= n_scan_idx;
        r_scan_size <= i_scan_size;
    end

    assign o_scan      = r_scan;
    assign o_scan_val  = r_scan_val;
    assign o_scan_idx  = r_scan_idx;
    assign o_scan_size = r_scan_size;

endmodule

// File: rtl/partition_fit_allocator.sv
// Top level of the partition fit allocator.
// Holds the request sequencer, the output register and the chain of
// pfa_cell slots. Depends on pfa_pkg and pfa_cell.
//
// Usage:
// Input words carry a request type, a slot index and a size on a
// valid/stall channel; result words carry a status and a slot index on a
// second valid/stall channel. The fit mode register is written on its own
// valid/ready channel, which is always ready.
// A load or restart word produces its result in the cycle after acceptance.
// An allocate word sends a search word down the chain of slot cells, one
// cell per cycle; its result passes through the launch register, every slot
// cell and the output register, and the block takes no new word until the
// search is done. A longer chain makes the search take longer.
// A new word is accepted only while no search is running and the output
// register is empty or being emptied; a stalled result holds its value.
// Reset clears all slot valid marks, the fit mode and the output valid flag;
// slot sizes are undefined until loaded, the result fields until written.
module partition_fit_allocator #(
    parameter int NUM_BLOCKS = 16,
    parameter int SIZE_BITS  = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [pfa_pkg::REQ_W-1:0]   i_req_type,
    input  logic [pfa_pkg::BIDX_W-1:0]  i_block_index,
    input  logic [pfa_pkg::SVAL_W-1:0]  i_size_value,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [pfa_pkg::STAT_W-1:0]  o_status,
    output logic [pfa_pkg::BIDX_W-1:0]  o_chosen_block,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [pfa_pkg::MODE_W-1:0]  i_cfg_data
);
    import pfa_pkg::*;

    localparam int IW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int SW = SIZE_BITS;

    t_state              r_state;
    t_state              n_state;
    logic [MODE_W-1:0]   r_mode;
    logic                r_out_valid;
    logic                n_out_valid;
    logic [STAT_W-1:0]   r_status;
    logic [STAT_W-1:0]   n_status;
    logic [BIDX_W-1:0]   r_chosen;
    logic [BIDX_W-1:0]   n_chosen;
    t_scan_ctl           r_launch;
    t_scan_ctl           n_launch;
    logic [SW-1:0]       r_launch_size;
    logic                in_accept;
    logic                out_load;
    logic [SW-1:0]       req_size;
    t_cell_cmd           cmd;
    logic [IW-1:0]       cmd_idx;
    logic [SW-1:0]       cmd_size;

    t_scan_ctl           w_scan [NUM_BLOCKS+1];
    logic [SW-1:0]       w_val  [NUM_BLOCKS+1];
    logic [IW-1:0]       w_idx  [NUM_BLOCKS+1];
    logic [SW-1:0]       w_size [NUM_BLOCKS+1];

    assign o_in_stall  = !((r_state == ST_IDLE) && (!r_out_valid || !i_out_stall));
    assign in_accept   = i_in_valid && !o_in_stall;
    assign req_size    = SW'(32'(i_size_value));
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_state      = r_state;
        n_launch     = '0;
        cmd          = '0;
        cmd_idx      = IW'(32'(i_block_index));
        cmd_size     = req_size;
        out_load     = 1'b0;
        n_status     = STAT_DONE;
        n_chosen     = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    unique case (i_req_type)
                        REQ_LOAD: begin
                            cmd.load = (32'(i_block_index) < 32'(NUM_BLOCKS));
                            out_load = 1'b1;
                        end
                        REQ_RESTART: begin
                            cmd.restart = 1'b1;
                            out_load    = 1'b1;
                        end
                        REQ_ALLOC: begin
                            n_launch.valid = 1'b1;
                            n_launch.best  = (r_mode == MODE_BEST);
                            n_launch.worst = (r_mode == MODE_WORST);
                            n_state        = ST_SCAN;
                        end
                        default: begin
                            out_load = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (w_scan[NUM_BLOCKS].valid) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                    if (w_scan[NUM_BLOCKS].found) begin
                        cmd.grant = 1'b1;
                        cmd_idx   = w_idx[NUM_BLOCKS];
                        cmd_size  = w_size[NUM_BLOCKS];
                        n_status  = STAT_GRANT;
                        n_chosen  = BIDX_W'(32'(w_idx[NUM_BLOCKS]));
                    end else begin
                        n_status  = STAT_MISS;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        n_out_valid = (r_out_valid && i_out_stall) || out_load;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_mode      <= MODE_FIRST;
            r_out_valid <= 1'b0;
            r_launch    <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_launch    <= n_launch;
            if (i_cfg_valid && o_cfg_ready) begin
                r_mode <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_status <= n_status;
            r_chosen <= n_chosen;
        end
        if (in_accept) begin
            r_launch_size <= req_size;
        end
    end

    assign w_scan[0] = r_launch;
    assign w_val[0]  = '0;
    assign w_idx[0]  = '0;
    assign w_size[0] = r_launch_size;

    for (genvar j = 0; j < NUM_BLOCKS; j++) begin : g_cell
        pfa_cell #(
            .SIZE_BITS (SW),
            .IDX_BITS  (IW),
            .INDEX     (j)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_cmd       (cmd),
            .i_cmd_idx   (cmd_idx),
            .i_cmd_size  (cmd_size),
            .i_scan      (w_scan[j]),
            .i_scan_val  (w_val[j]),
            .i_scan_idx  (w_idx[j]),
            .i_scan_size (w_size[j]),
            .o_scan      (w_scan[j+1]),
            .o_scan_val  (w_val[j+1]),
            .o_scan_idx  (w_idx[j+1]),
            .o_scan_size (w_size[j+1])
        );
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_chosen_block = r_chosen;

endmodule

// File: rtl/pfa_checker.sv
// Port-level checker for the partition fit allocator, bound to the top level.
// Depends on pfa_pkg and partition_fit_allocator.
module pfa_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_stall,
    input logic [pfa_pkg::REQ_W-1:0]   i_req_type,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input logic [pfa_pkg::STAT_W-1:0]  o_status,
    input logic [pfa_pkg::BIDX_W-1:0]  o_chosen_block
);
    import pfa_pkg::*;

    a_no_grant_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != STAT_GRANT)) |-> (o_chosen_block == '0))
        else $error("non-grant result carries a slot index");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
        (o_out_valid && $stable(o_status) && $stable(o_chosen_block)))
        else $error("stalled result changed or vanished");

    a_full_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |-> o_in_stall)
        else $error("input taken while a stalled result is pending");

    a_load_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && (i_req_type == REQ_LOAD)) |=>
        (o_out_valid && (o_status == STAT_DONE)))
        else $error("load word did not complete in one cycle");

endmodule

bind partition_fit_allocator pfa_checker u_pfa_checker (.*);

// File: tb/tb_top.sv
// Self-checking testbench for partition_fit_allocator: loads, restarts and
// first, best and worst fit allocations under random idling and stalls.
// Depends on pfa_pkg and the partition_fit_allocator RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pfa_pkg::*;

    localparam int                SLOTS        = 16;
    localparam int                SETTLE_TICKS = SLOTS + 8;
    localparam logic [REQ_W-1:0]  REQ_NOP      = 2'd3;
    localparam logic [MODE_W-1:0] MODE_SPARE   = 2'd3;

    typedef struct packed {
        logic [REQ_W-1:0]  kind;
        logic [BIDX_W-1:0] slot;
        logic [SVAL_W-1:0] size;
    } t_part_req;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [BIDX_W-1:0] block;
    } t_part_grant;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [REQ_W-1:0] req_type = '0;
    logic [BIDX_W-1:0] block_index = '0;
    logic [SVAL_W-1:0] size_value = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [STAT_W-1:0] status;
    logic [BIDX_W-1:0] chosen_block;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [MODE_W-1:0] cfg_data = '0;

    bit [SVAL_W-1:0] orig_size_q [SLOTS];
    bit [SVAL_W-1:0] rem_size_q [SLOTS];
    bit slot_live_q [SLOTS];
    logic [MODE_W-1:0] fit_mode_q = MODE_FIRST;

    t_part_req pending_reqs [$];
    t_part_grant expected_grants [$];
    t_part_req cur_req;
    bit word_done;
    int reqs_in_flight = 0;
    int idle_pct = 0;
    int stall_pct = 0;
    int fail_count = 0;

    partition_fit_allocator uut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_req_type     (req_type),
        .i_block_index  (block_index),
        .i_size_value   (size_value),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_status       (status),
        .o_chosen_block (chosen_block),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_data     (cfg_data)
    );

    always #2 clk = ~clk;

    function automatic t_part_grant place_request(input t_part_req r);
        t_part_grant g;
        bit found;
        int pick;
        g.status = STAT_DONE;
        g.block = '0;
        found = 1'b0;
        pick = 0;
        case (r.kind)
            REQ_LOAD: begin
                orig_size_q[r.slot] = r.size;
                rem_size_q[r.slot] = r.size;
                slot_live_q[r.slot] = 1'b1;
            end
            REQ_RESTART: begin
                for (int j = 0; j < SLOTS; j++) rem_size_q[j] = orig_size_q[j];
            end
            REQ_ALLOC: begin
                for (int j = 0; j < SLOTS; j++) begin
                    if (slot_live_q[j] && rem_size_q[j] >= r.size) begin
                        if (!found) begin
                            found = 1'b1;
                            pick = j;
                        end else if ((fit_mode_q == MODE_BEST && rem_size_q[j] < rem_size_q[pick])
                                || (fit_mode_q == MODE_WORST
                                    && rem_size_q[j] > rem_size_q[pick])) begin
                            pick = j;
                        end
                    end
                end
                if (found) begin
                    rem_size_q[pick] = rem_size_q[pick] - r.size;
                    g.status = STAT_GRANT;
                    g.block = pick[BIDX_W-1:0];
                end else begin
                    g.status = STAT_MISS;
                end
            end
            default: ;
        endcase
        return g;
    endfunction

    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            word_done = !in_valid;
            if (in_valid && !in_stall) begin
                expected_grants.push_back(place_request(cur_req));
                reqs_in_flight--;
                word_done = 1'b1;
            end
            if (word_done) begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    cur_req = pending_reqs.pop_front();
                    in_valid <= 1'b1;
                    req_type <= cur_req.kind;
                    block_index <= cur_req.slot;
                    size_value <= cur_req.size;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk) begin
        t_part_grant exp_g;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_grants.size() == 0) begin
                $error("unexpected result word: status %0d, chosen_block %0d",
                       status, chosen_block);
                fail_count++;
            end else begin
                exp_g = expected_grants.pop_front();
                if (status !== exp_g.status) begin
                    $error("status: expected %0d, actual %0d", exp_g.status, status);
                    fail_count++;
                end
                if (chosen_block !== exp_g.block) begin
                    $error("chosen_block: expected %0d, actual %0d", exp_g.block, chosen_block);
                    fail_count++;
                end
            end
        end
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic push_req(input logic [REQ_W-1:0] kind, input logic [BIDX_W-1:0] slot,
                            input logic [SVAL_W-1:0] size);
        t_part_req r;
        r.kind = kind;
        r.slot = slot;
        r.size = size;
        reqs_in_flight++;
        pending_reqs.push_back(r);
    endtask

    task automatic drain_allocator();
        do @(posedge clk); while (reqs_in_flight != 0 || expected_grants.size() != 0);
    endtask

    task automatic write_fit_mode(input logic [MODE_W-1:0] m);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= m;
        do @(posedge clk); while (!cfg_ready);
        fit_mode_q = m;
        cfg_valid <= 1'b0;
    endtask

    task automatic gen_episode(inout int budget);
        int n_load;
        int n_alloc;
        int regime;
        int pick;
        logic [SVAL_W-1:0] span;
        regime = $urandom_range(9);
        span = (regime < 5) ? 16'd15 : ((regime < 8) ? 16'd2000 : 16'hFFFF);
        n_load = $urandom_range(1, 6);
        n_alloc = $urandom_range(3, 10);
        repeat (n_load) push_req(REQ_LOAD, BIDX_W'($urandom_range(SLOTS - 1)),
                                 SVAL_W'($urandom_range(span)));
        repeat (n_alloc) begin
            pick = $urandom_range(19);
            if (pick == 0)
                push_req(REQ_RESTART, BIDX_W'($urandom), SVAL_W'($urandom));
            else if (pick == 1)
                push_req(REQ_NOP, BIDX_W'($urandom), SVAL_W'($urandom));
            else if (pick == 2)
                push_req(REQ_W'($urandom), BIDX_W'($urandom), SVAL_W'($urandom));
            else if (pick == 3)
                push_req(REQ_ALLOC, BIDX_W'($urandom),
                         $urandom_range(1) ? 16'hFFFF : 16'h0000);
            else
                push_req(REQ_ALLOC, BIDX_W'($urandom), SVAL_W'($urandom_range(span)));
        end
        budget -= n_load + n_alloc;
    endtask

    initial begin
        int idle_plan [4];
        int stall_plan [4];
        logic [MODE_W-1:0] mode_plan [8];
        int budget;
        idle_plan = '{0, 48, 0, 31};
        stall_plan = '{0, 0, 48, 31};
        mode_plan = '{MODE_FIRST, MODE_BEST, MODE_WORST, MODE_SPARE,
                      MODE_BEST, MODE_WORST, MODE_FIRST, MODE_BEST};
        mode_plan[7] = MODE_W'($urandom_range(3));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_fit_mode(MODE_FIRST);
        push_req(REQ_ALLOC, 4'd0, 16'd1);
        push_req(REQ_NOP, 4'd15, 16'hFFFF);
        push_req(REQ_LOAD, 4'd0, 16'd0);
        push_req(REQ_LOAD, 4'd15, 16'hFFFF);
        push_req(REQ_LOAD, 4'd5, 16'd100);
        push_req(REQ_LOAD, 4'd6, 16'd100);
        push_req(REQ_LOAD, 4'd7, 16'd40);
        push_req(REQ_ALLOC, 4'd0, 16'd0);
        push_req(REQ_ALLOC, 4'd15, 16'hFFFF);
        push_req(REQ_ALLOC, 4'd0, 16'hFFFF);
        push_req(REQ_ALLOC, 4'd0, 16'd50);
        push_req(REQ_RESTART, 4'd15, 16'hFFFF);
        drain_allocator();

        write_fit_mode(MODE_BEST);
        push_req(REQ_ALLOC, 4'd0, 16'd40);
        push_req(REQ_ALLOC, 4'd0, 16'd1);
        push_req(REQ_ALLOC, 4'd0, 16'd0);
        drain_allocator();

        write_fit_mode(MODE_WORST);
        push_req(REQ_ALLOC, 4'd0, 16'd1);
        push_req(REQ_RESTART, 4'd0, 16'd0);
        push_req(REQ_LOAD, 4'd15, 16'd0);
        push_req(REQ_ALLOC, 4'd0, 16'd100);
        push_req(REQ_ALLOC, 4'd0, 16'd60);
        drain_allocator();

        write_fit_mode(MODE_SPARE);
        push_req(REQ_ALLOC, 4'd0, 16'd1);
        push_req(REQ_ALLOC, 4'd0, 16'd30);
        drain_allocator();

        for (int ph = 0; ph < 8; ph++) begin
            idle_pct = idle_plan[ph / 2];
            stall_pct = stall_plan[ph / 2];
            write_fit_mode(mode_plan[ph]);
            budget = 125;
            while (budget > 0) gen_episode(budget);
            drain_allocator();
        end

        repeat (SETTLE_TICKS) @(posedge clk);
        if (fail_count == 0 && expected_grants.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
